// ===== rtl/signed_integer_divider_assert.svh =====
// Assertion macros for the signed integer divider checker.
// Included by the checker module only; depends on nothing else.
`ifndef SIGNED_INTEGER_DIVIDER_ASSERT_SVH
`define SIGNED_INTEGER_DIVIDER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SID_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("signed_integer_divider: check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("signed_integer_divider: check failed");

`endif

// ===== rtl/sid_pkg.sv =====
// Shared types for the signed integer divider.
// Used by sid_stage and signed_integer_divider; depends on nothing.
package sid_pkg;

  // How the final quotient is formed for one request.
  typedef enum logic [1:0] {
    KIND_NORMAL,   // quotient taken from the divider array
    KIND_ZERO,     // dividend is zero, quotient is zero
    KIND_SAT       // divisor is zero and dividend is not, quotient is the largest positive value
  } sid_kind_t;

  // Control that travels alongside the data through every stage.
  typedef struct packed {
    logic      valid;
    logic      neg;
    sid_kind_t kind;
  } sid_ctrl_t;

endpackage

// ===== rtl/sid_stage.sv =====
// One restoring division step with its pipeline registers.
// Depends on sid_pkg for the control struct.
module sid_stage
  import sid_pkg::*;
#(
  parameter int W = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  sid_ctrl_t       ctrl_i,
  input  logic [W-2:0]    rem_i,
  input  logic [W-1:0]    nq_i,
  input  logic [W-1:0]    den_i,
  output sid_ctrl_t       ctrl_o,
  output logic [W-2:0]    rem_o,
  output logic [W-1:0]    nq_o,
  output logic [W-1:0]    den_o
);

  sid_ctrl_t    ctrl_r;
  logic [W-2:0] rem_r, rem_nxt;
  logic [W-1:0] nq_r, nq_nxt;
  logic [W-1:0] den_r;
  logic [W:0]   diff;
  logic         ge;

  // Bring in the next dividend bit and trial-subtract the divisor.
  // The remainder stays below the divisor, so it fits in W-1 bits.
  always_comb begin
    diff    = {1'b0, rem_i, nq_i[W-1]} - {1'b0, den_i};
    ge      = ~diff[W];
    rem_nxt = ge ? diff[W-2:0] : {rem_i[W-3:0], nq_i[W-1]};
    // Dividend bits leave at the top while quotient bits enter at the bottom.
    nq_nxt  = {nq_i[W-2:0], ge};
  end

  // Control register, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  // Data registers, no reset needed.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      den_r <= den_i;
    end
  end

  assign ctrl_o = ctrl_r;
  assign rem_o  = rem_r;
  assign nq_o   = nq_r;
  assign den_o  = den_r;

endmodule

// ===== rtl/signed_integer_divider.sv =====
// Signed integer divider, quotient truncated toward zero.
// Pipeline: one operand stage, one restoring step per quotient bit, and one sign and
// saturation stage. Throughput is one request per cycle while no result is held.
// A held result stalls the whole pipeline at once; the direct path from out_ready to in_ready
// sets that stall. Synchronous active-low reset clears all valid bits; no data is reset.
// Depends on sid_pkg and sid_stage.
module signed_integer_divider
  import sid_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_dividend,
  input  logic signed [DATA_WIDTH-1:0] in_divisor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_quotient
);

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ONE    = W'(1);

  // Pipeline advance: everything moves unless a result is held at the output.
  logic adv;

  sid_ctrl_t    ctrl_c [0:W];
  logic [W-2:0] rem_c  [0:W];
  logic [W-1:0] nq_c   [0:W];
  logic [W-1:0] den_c  [0:W];

  sid_ctrl_t    ctrl0_r, ctrl0_nxt;
  logic [W-1:0] nq0_r, nq0_nxt;
  logic [W-1:0] den0_r, den0_nxt;

  logic         out_valid_r;
  logic [W-1:0] quot_r, quot_nxt;
  logic [W-1:0] q_fin;

  assign adv      = ~out_valid_r | out_ready;
  assign in_ready = adv;

  // Operand stage: classify special cases and take magnitudes.
  always_comb begin
    ctrl0_nxt.valid = in_valid;
    ctrl0_nxt.neg   = in_dividend[W-1] ^ in_divisor[W-1];
    if (in_dividend == '0) begin
      ctrl0_nxt.kind = KIND_ZERO;
    end else if (in_divisor == '0) begin
      ctrl0_nxt.kind = KIND_SAT;
    end else begin
      ctrl0_nxt.kind = KIND_NORMAL;
    end
    nq0_nxt  = in_dividend[W-1] ? (~in_dividend + ONE) : in_dividend;
    den0_nxt = in_divisor[W-1]  ? (~in_divisor + ONE)  : in_divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl0_r <= '0;
    end else if (adv) begin
      ctrl0_r <= ctrl0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nq0_r  <= nq0_nxt;
      den0_r <= den0_nxt;
    end
  end

  assign ctrl_c[0] = ctrl0_r;
  assign rem_c[0]  = '0;
  assign nq_c[0]   = nq0_r;
  assign den_c[0]  = den0_r;

  // Restoring array: one stage per quotient bit, most significant first.
  for (genvar i = 0; i < W; i++) begin : g_step
    sid_stage #(.W(W)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .ctrl_i (ctrl_c[i]),
      .rem_i  (rem_c[i]),
      .nq_i   (nq_c[i]),
      .den_i  (den_c[i]),
      .ctrl_o (ctrl_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .nq_o   (nq_c[i+1]),
      .den_o  (den_c[i+1])
    );
  end

  // Sign and saturation stage.
  assign q_fin = nq_c[W];

  always_comb begin
    unique case (ctrl_c[W].kind)
      KIND_ZERO: quot_nxt = '0;
      KIND_SAT:  quot_nxt = MAXPOS;
      KIND_NORMAL: begin
        if (ctrl_c[W].neg) begin
          quot_nxt = ~q_fin + ONE;
        end else if (q_fin[W-1]) begin
          // Only the most negative value over minus one lands here.
          quot_nxt = MAXPOS;
        end else begin
          quot_nxt = q_fin;
        end
      end
      default:   quot_nxt = MAXPOS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctrl_c[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quot_r <= quot_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_quotient = quot_r;

endmodule

// ===== rtl/sid_checker.sv =====
// Port-level checker for the signed integer divider, bound to the top level.
// Depends on signed_integer_divider_assert.svh for its assertion macros.
`include "signed_integer_divider_assert.svh"

module sid_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] out_quotient
);

  // Reset empties the output register.
  `SID_ASSERT_NEXT(a_reset_clears, !rst_n, !out_valid)

  // The input takes a request exactly when the output is free or being drained.
  `SID_ASSERT_NOW(a_ready_follows_output, rst_n, in_ready == (!out_valid || out_ready))

  // A held result stays put until it is taken.
  `SID_ASSERT_NEXT(a_result_holds, rst_n && out_valid && !out_ready,
                   !rst_n || (out_valid && $stable(out_quotient)))

  // A stalled output never lets a new request in.
  `SID_ASSERT_NOW(a_no_accept_on_stall, rst_n && out_valid && !out_ready,
                  !(in_valid && in_ready))

endmodule

bind signed_integer_divider sid_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sid_checker (.*);

// ===== bench/tb_signed_integer_divider.sv =====
// Self-checking testbench for signed_integer_divider: directed edge cases, then random requests.
// Depends only on the RTL of the divider. Expected quotients come from a behavioural restoring
// divider held here, and are compared in order with what the block returns.
module tb_signed_integer_divider;

  localparam int DW = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQUESTS = 1800;
  localparam logic signed [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

  typedef struct {
    logic signed [DW-1:0] dividend;
    logic signed [DW-1:0] divisor;
    bit                   wait_idle;  // hold this request back until nothing is in flight
  } div_request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DW-1:0] in_dividend = '0;
  logic signed [DW-1:0] in_divisor = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DW-1:0] out_quotient;

  div_request_t pending_q[$];
  logic signed [DW-1:0] quotient_q[$];
  int fail_count = 0;
  int cycle_count = 0;

  // Idle and stall state for the two sides.
  int send_wait = 0;
  int send_run = 0;
  bit send_quiet = 1'b0;
  int hold_wait = 0;
  int hold_run = 0;
  bit hold_quiet = 1'b0;

  signed_integer_divider #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_dividend(in_dividend),
    .in_divisor(in_divisor),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_quotient(out_quotient)
  );

  // Quotient truncated toward zero, with zero dividend and zero divisor handled first and overflow saturated.
  function automatic logic signed [DW-1:0] predict_quotient(logic signed [DW-1:0] num,
                                                            logic signed [DW-1:0] den);
    logic [DW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [DW-1:0] quo;
    logic [DW:0] partial;
    logic negate;
    if (num == 0) return '0;
    if (den == 0) return MOST_POS;
    negate = num[DW-1] ^ den[DW-1];
    num_mag = num[DW-1] ? ~num + 1'b1 : num;
    den_mag = den[DW-1] ? ~den + 1'b1 : den;
    partial = '0;
    quo = '0;
    for (int i = DW - 1; i >= 0; i--) begin
      partial = {partial[DW-1:0], num_mag[i]};
      if (partial >= {1'b0, den_mag}) begin
        partial = partial - {1'b0, den_mag};
        quo[i] = 1'b1;
      end
    end
    if (negate) return ~quo + 1'b1;
    if (quo > MOST_POS) return MOST_POS;
    return quo;
  endfunction

  // Wait length for one request, in runs that are either free of gaps or fully random.
  function automatic int draw_wait(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      quiet = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(10, 60);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  // Operand with a random magnitude width and a random sign.
  function automatic logic signed [DW-1:0] spread_operand();
    logic signed [DW-1:0] v;
    v = $urandom() >> $urandom_range(0, DW - 1);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // One of the values at the edges of the signed range.
  function automatic logic signed [DW-1:0] edge_operand();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 1;
      2: return -1;
      3: return MOST_NEG;
      default: return MOST_POS;
    endcase
  endfunction

  task automatic add_request(logic signed [DW-1:0] a, logic signed [DW-1:0] b, bit hold);
    div_request_t req;
    req.dividend = a;
    req.divisor = b;
    req.wait_idle = hold;
    pending_q.push_back(req);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Request driver: records the expected quotient on each accepted request.
  always @(posedge clk) begin
    div_request_t req;
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        quotient_q.push_back(predict_quotient(in_dividend, in_divisor));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].wait_idle && quotient_q.size() != 0)) begin
          req = pending_q.pop_front();
          in_valid <= 1'b1;
          in_dividend <= req.dividend;
          in_divisor <= req.divisor;
          send_wait = draw_wait(send_run, send_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each quotient with the oldest expectation, stalls at random.
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      gap = hold_wait;
      if (out_valid && out_ready) begin
        if (quotient_q.size() == 0) begin
          $error("quotient: unexpected result %0d", out_quotient);
          fail_count++;
        end else begin
          if (out_quotient !== quotient_q[0]) begin
            $error("quotient: expected %0d, actual %0d", quotient_q[0], out_quotient);
            fail_count++;
          end
          void'(quotient_q.pop_front());
        end
        gap = draw_wait(hold_run, hold_quiet);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        hold_wait = gap - 1;
      end else begin
        out_ready <= 1'b1;
        hold_wait = 0;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;

    // Directed part: zero operands, overflow, range edges and every sign pairing.
    add_request(0, 0, 1'b0);
    add_request(0, -1, 1'b0);
    add_request(0, MOST_NEG, 1'b0);
    add_request(5, 0, 1'b0);
    add_request(-5, 0, 1'b0);
    add_request(MOST_NEG, 0, 1'b0);
    add_request(MOST_NEG, -1, 1'b0);
    add_request(MOST_NEG, 1, 1'b0);
    add_request(MOST_NEG, MOST_NEG, 1'b0);
    add_request(MOST_NEG, MOST_POS, 1'b0);
    add_request(MOST_POS, MOST_POS, 1'b0);
    add_request(MOST_POS, -1, 1'b0);
    add_request(MOST_POS, MOST_NEG, 1'b0);
    add_request(-1, MOST_NEG, 1'b0);
    add_request(-1, -1, 1'b0);
    add_request(7, 2, 1'b0);
    add_request(-7, 2, 1'b0);
    add_request(7, -2, 1'b0);
    add_request(-7, -2, 1'b0);
    add_request(1, MOST_POS, 1'b0);
    add_request(MOST_NEG, 2, 1'b0);
    add_request(32'sh5555_5555, 3, 1'b0);
    add_request(32'shAAAA_AAAA, -3, 1'b0);
    add_request(100, 7, 1'b0);

    // Random part; for every 400th request the sender lets the pipeline drain first.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          a = spread_operand();
          b = spread_operand();
        end
        4, 5: begin
          a = $urandom();
          b = $urandom();
        end
        6: begin
          a = $urandom();
          b = $urandom_range(1, 16);
          if ($urandom_range(0, 1) == 1) b = -b;
        end
        7: begin
          a = edge_operand();
          b = spread_operand();
        end
        8: begin
          a = spread_operand();
          b = edge_operand();
        end
        default: begin
          // Divisor close to the dividend, so the quotient lands near plus or minus one.
          a = spread_operand();
          b = a + $signed($urandom_range(0, 2)) - 1;
          if ($urandom_range(0, 1) == 1) b = -b;
        end
      endcase
      add_request(a, b, (n % 400) == 0);
    end

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (quotient_q.size() != 0) @(posedge clk);
    repeat (DW + 8) @(posedge clk);

    if (fail_count == 0 && quotient_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sid_pkg.sv
rtl/sid_stage.sv
rtl/signed_integer_divider.sv
rtl/sid_checker.sv
bench/tb_signed_integer_divider.sv
